### sv/spq_pkg.sv
package spq_pkg;
	localparam int DefaultDepth = 32;
	localparam int HandleW = 16;
	localparam int KeyW = 32;
	localparam int PosW = 6;

	typedef enum logic [2:0] {
		FN_SORTED_INSERT = 3'd0,
		FN_INSERT_AT = 3'd1,
		FN_POP = 3'd2,
		FN_READ_AT = 3'd3,
		FN_REMOVE_AT = 3'd4,
		FN_FIND = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture the request and scan the chain
		logic shift_in; // open a slot at the target and write the entry
		logic shift_out;// close the slot at the target
		logic capture;  // latch the result registers
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_insert;
		logic is_remove;
		logic ok;
	} spq_stat_t;
endpackage

### sv/sorted_insert_priority_queue_unit.sv
// Sorted priority queue of QUEUE_DEPTH entries (handle + 32-bit key).
// Request channel s_axis_*: one operation per transfer (sorted insert, insert
// at, pop, read at, remove at, find). Result channel m_axis_*: exactly one
// result transfer per request, in order.
// cfg_valid/cfg_ready/cfg_data write key_select (0 priority, 1 duration);
// it is sampled when an insert is accepted. Write only while idle.
// An accepted request goes to the execute state, where its result is captured,
// and then to the output state. The controller handles one operation at a
// time (load/scan, execute, output); no new request is taken before the result.
// The cell chain compares all cells in parallel in the load cycle and shifts
// the whole chain at once in the execute state on insert or remove.
// Reset clears the entry count and the controller; cell contents are left
// as they are and are never read before being written.
// A stalled receiver holds the result steady and blocks new requests until
// the result transfer completes.
module sorted_insert_priority_queue_unit #(
	parameter int QUEUE_DEPTH = spq_pkg::DefaultDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: func[2:0], item_handle[18:3], priority_value[50:19],
	// duration_value[82:51], position[88:83], zero fill to 96
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: status[2:0], out_handle[18:3], out_key[50:19],
	// found_position[56:51], entry_count[62:57], zero fill to 64
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import spq_pkg::*;

	spq_cmd_t  cmd;
	spq_stat_t stat;
	logic busy, in_fire, out_fire, key_select_q;
	logic [2:0] status;
	logic [HandleW-1:0] out_handle;
	logic [KeyW-1:0] out_key;
	logic [PosW-1:0] found_position, entry_count;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_select_q <= 1'b0;
		else if (cfg_valid) key_select_q <= cfg_data;
	end

	spq_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .stat, .cmd, .busy,
		.out_valid(m_axis_tvalid)
	);

	spq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd,
		.key_select(key_select_q),
		.func(s_axis_tdata[2:0]),
		.item_handle(s_axis_tdata[18:3]),
		.priority_value(s_axis_tdata[50:19]),
		.duration_value(s_axis_tdata[82:51]),
		.position(s_axis_tdata[88:83]),
		.stat, .status, .out_handle, .out_key, .found_position, .entry_count
	);

	assign m_axis_tdata = {1'b0, entry_count, found_position, out_key, out_handle, status};
endmodule

### sv/spq_ctrl.sv
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_fire,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_cmd_t  cmd,
	output logic             busy,
	output logic             out_valid
);
	import spq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
	state_t state_q;

	always_comb begin
		cmd.load = in_fire;
		cmd.shift_in = (state_q == S_EXEC) && stat.ok && stat.is_insert;
		cmd.shift_out = (state_q == S_EXEC) && stat.ok && stat.is_remove;
		cmd.capture = (state_q == S_EXEC);
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (out_fire) begin
						state_q <= S_IDLE;
						out_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == (state_q == S_OUT)) else $error("out_valid mismatch");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_in && cmd.shift_out)) else $error("both shifts");
	a_exec_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> out_valid) else $error("exec not followed by out");
endmodule

### sv/spq_datapath.sv
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::DefaultDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_pkg::spq_cmd_t          cmd,
	input  logic                       key_select,
	input  logic [2:0]                 func,
	input  logic [spq_pkg::HandleW-1:0] item_handle,
	input  logic [spq_pkg::KeyW-1:0]   priority_value,
	input  logic [spq_pkg::KeyW-1:0]   duration_value,
	input  logic [spq_pkg::PosW-1:0]   position,
	output spq_pkg::spq_stat_t         stat,
	output logic [2:0]                 status,
	output logic [spq_pkg::HandleW-1:0] out_handle,
	output logic [spq_pkg::KeyW-1:0]   out_key,
	output logic [spq_pkg::PosW-1:0]   found_position,
	output logic [spq_pkg::PosW-1:0]   entry_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int XW = (CW > PosW) ? CW : PosW;

	// shifting cell chain: each cell compares against the request in parallel
	logic [HandleW-1:0] cell_handle_q [QUEUE_DEPTH];
	logic [KeyW-1:0]    cell_key_q [QUEUE_DEPTH];
	logic [CW-1:0]      fill_q;

	logic [2:0]         func_q;
	logic [HandleW-1:0] handle_q;
	logic [KeyW-1:0]    key_q;
	logic [CW-1:0]      tgt_q;
	logic [2:0]         st_q;
	logic               is_ins_q, is_rem_q;

	logic [KeyW-1:0]    new_key;
	logic [QUEUE_DEPTH-1:0] gt_vec, hit_vec;
	logic [CW-1:0]      gt_pos, hit_pos, pos_ext, tgt_n;
	logic [XW-1:0]      pos_wide, fill_wide;
	logic               hit_any;
	logic [2:0]         st_n;

	assign new_key = key_select ? duration_value : priority_value;
	assign pos_ext = CW'(position);
	// range compares at the wider of the two widths
	assign pos_wide = XW'(position);
	assign fill_wide = XW'(fill_q);

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt_vec[i] = (CW'(i) < fill_q) && (cell_key_q[i] > new_key);
			hit_vec[i] = (CW'(i) < fill_q) && (cell_handle_q[i] == item_handle);
		end
	end

	// priority encoders: first set bit from the head
	always_comb begin
		gt_pos = fill_q;
		hit_pos = '0;
		hit_any = 1'b0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (gt_vec[i]) gt_pos = CW'(i);
			if (hit_vec[i]) begin
				hit_pos = CW'(i);
				hit_any = 1'b1;
			end
		end
	end

	always_comb begin
		st_n = ST_OK;
		tgt_n = '0;
		case (func)
			FN_SORTED_INSERT, FN_INSERT_AT: begin
				if (fill_q >= CW'(QUEUE_DEPTH)) st_n = ST_FULL;
				else if (func == FN_SORTED_INSERT) tgt_n = gt_pos;
				else tgt_n = (pos_wide < fill_wide) ? pos_ext : fill_q;
			end
			FN_POP, FN_READ_AT, FN_REMOVE_AT: begin
				tgt_n = (func == FN_POP) ? '0 : pos_ext;
				if (fill_q == '0) st_n = ST_EMPTY;
				else if (func != FN_POP && (pos_wide >= fill_wide))
					st_n = ST_RANGE;
			end
			FN_FIND: begin
				if (hit_any) tgt_n = hit_pos;
				else st_n = ST_NOTFOUND;
			end
			default: st_n = ST_RANGE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			handle_q <= item_handle;
			key_q <= new_key;
			tgt_q <= (st_n == ST_OK) ? tgt_n : '0;
			st_q <= st_n;
			is_ins_q <= (func == FN_SORTED_INSERT) || (func == FN_INSERT_AT);
			is_rem_q <= (func == FN_POP) || (func == FN_REMOVE_AT);
		end
		if (cmd.shift_in) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (CW'(i) == tgt_q) begin
					cell_handle_q[i] <= handle_q;
					cell_key_q[i] <= key_q;
				end
			end
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (CW'(i) > tgt_q) begin
					cell_handle_q[i] <= cell_handle_q[i-1];
					cell_key_q[i] <= cell_key_q[i-1];
				end
			end
		end
		if (cmd.shift_out) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				if (CW'(i) >= tgt_q) begin
					cell_handle_q[i] <= cell_handle_q[i+1];
					cell_key_q[i] <= cell_key_q[i+1];
				end
			end
		end
		// result capture in the execute cycle, before any shift lands
		if (cmd.capture) begin
			if (st_q == ST_OK && (func_q == FN_POP || func_q == FN_READ_AT)) begin
				out_handle <= cell_handle_q[tgt_q[IW-1:0]];
				out_key <= cell_key_q[tgt_q[IW-1:0]];
			end else begin
				out_handle <= '0;
				out_key <= '0;
			end
			status <= st_q;
			found_position <= PosW'(tgt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fill_q <= '0;
		else if (cmd.shift_in) fill_q <= fill_q + 1'b1;
		else if (cmd.shift_out) fill_q <= fill_q - 1'b1;
	end

	assign entry_count = PosW'(fill_q);
	assign stat.is_insert = is_ins_q;
	assign stat.is_remove = is_rem_q;
	assign stat.ok = (st_q == ST_OK);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH)) else $error("fill overflow");
	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_in |-> fill_q < CW'(QUEUE_DEPTH)) else $error("insert when full");
	a_no_rem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_out |-> fill_q != '0) else $error("remove when empty");
endmodule
